### src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the mouse packet tracker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define PMPT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pmpt assertion failed");

// Checked on every rising edge, reset included.
`define PMPT_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("pmpt assertion failed");

`endif

### src/pmpt_pkg.sv
// ---------------------------------------------------------------------------
// pmpt_pkg
// Types and constants shared by the mouse packet tracker modules.
// ---------------------------------------------------------------------------
`default_nettype none

package pmpt_pkg;

    localparam int COORD_BITS = 12;
    localparam int CFG_BITS   = 12;
    localparam int OUT_BITS   = 12;
    localparam int QDEPTH     = 2;

    localparam int HDR_SYNC_BIT  = 3;
    localparam int HDR_XSIGN_BIT = 4;
    localparam int HDR_YSIGN_BIT = 5;

    localparam logic [COORD_BITS-1:0] RESET_X = COORD_BITS'(800);
    localparam logic [COORD_BITS-1:0] RESET_Y = COORD_BITS'(400);
    localparam logic [CFG_BITS-1:0]   RESET_WIDTH  = CFG_BITS'(1920);
    localparam logic [CFG_BITS-1:0]   RESET_HEIGHT = CFG_BITS'(1080);

    typedef enum logic {
        CFG_SCREEN_WIDTH  = 1'b0,
        CFG_SCREEN_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_X    = 2'd1,
        PH_Y    = 2'd2
    } t_phase;

    typedef struct packed {
        logic       x_neg;
        logic       y_neg;
        logic [1:0] buttons;
        logic [7:0] dx;
        logic [7:0] dy;
    } t_packet;

endpackage

`default_nettype wire

### src/pmpt_front.sv
// ---------------------------------------------------------------------------
// pmpt_front
// Byte framer: hunts for a header byte, collects the two delta bytes and
// hands each complete packet to the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module pmpt_front
    import pmpt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_stall,
    input  wire logic       i_full,
    output logic            o_push,
    output t_packet         o_packet
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_header, n_header;
    logic [7:0] r_dx, n_dx;
    logic       w_accept;

    assign o_stall  = i_full;
    assign w_accept = i_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
        end else begin
            r_phase <= n_phase;
        end
        r_header <= n_header;
        r_dx     <= n_dx;
    end

    always_comb begin
        n_phase  = r_phase;
        n_header = r_header;
        n_dx     = r_dx;
        o_push   = 1'b0;
        if (w_accept) begin
            unique case (r_phase)
                PH_X: begin
                    n_dx    = i_rx_byte;
                    n_phase = PH_Y;
                end
                PH_Y: begin
                    o_push  = 1'b1;
                    n_phase = PH_HUNT;
                end
                default: begin
                    if (i_rx_byte[HDR_SYNC_BIT]) begin
                        n_header = i_rx_byte;
                        n_phase  = PH_X;
                    end else begin
                        n_phase  = PH_HUNT;
                    end
                end
            endcase
        end
    end

    assign o_packet.x_neg   = r_header[HDR_XSIGN_BIT];
    assign o_packet.y_neg   = r_header[HDR_YSIGN_BIT];
    assign o_packet.buttons = r_header[1:0];
    assign o_packet.dx      = r_dx;
    assign o_packet.dy      = i_rx_byte;

endmodule

`default_nettype wire

### src/pmpt_queue.sv
// ---------------------------------------------------------------------------
// pmpt_queue
// Short packet queue between the framer and the position unit. The depth
// is a power of two so the pointers wrap on their own.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pmpt_queue
    import pmpt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_packet i_packet,
    output logic         o_full,
    output logic         o_valid,
    output t_packet      o_packet,
    input  wire logic    i_pop
);

    localparam int PTR_BITS = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_BITS = $clog2(QDEPTH + 1);

    t_packet               r_mem [QDEPTH];
    logic [PTR_BITS-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic                  w_push, w_pop;

    assign o_full   = (r_count == CNT_BITS'(QDEPTH));
    assign o_valid  = (r_count != '0);
    assign o_packet = r_mem[r_rd_ptr];
    assign w_push   = i_push && !o_full;
    assign w_pop    = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = w_push ? PTR_BITS'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = w_pop  ? PTR_BITS'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = CNT_BITS'(r_count + 1'b1);
        end else if (w_pop && !w_push) begin
            n_count = CNT_BITS'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_packet;
        end
    end

    `PMPT_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_BITS'(QDEPTH))
    `PMPT_ASSERT(a_pop_drains, i_clk, i_rst_n,
        (w_pop && !w_push) |=> (r_count == CNT_BITS'($past(r_count) - 1'b1)))
    `PMPT_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (r_count == '0))

endmodule

`default_nettype wire

### src/pmpt_back.sv
// ---------------------------------------------------------------------------
// pmpt_back
// Position unit: applies each packet's deltas to the kept position, clamps
// to the screen limits and holds the result in the output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pmpt_back
    import pmpt_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_idx,
    input  wire logic [CFG_BITS-1:0] i_cfg_data,
    input  wire logic                i_q_valid,
    input  wire t_packet             i_packet,
    output logic                     o_pop,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [OUT_BITS-1:0]      o_pos_x,
    output logic [OUT_BITS-1:0]      o_pos_y,
    output logic [1:0]               o_buttons
);

    localparam int SUM_BITS = COORD_BITS + 2;
    localparam int LIM_BITS = ((COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS) + 1;
    localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

    function automatic logic [COORD_BITS-1:0] cap_limit(input logic [CFG_BITS-1:0] lim);
        logic [LIM_BITS-1:0] ext;
        ext = LIM_BITS'(lim);
        if (ext > LIM_BITS'(COORD_MAX)) begin
            return COORD_MAX;
        end
        return COORD_BITS'(ext);
    endfunction

    function automatic logic [COORD_BITS-1:0] move_axis(
        input logic [COORD_BITS-1:0] pos,
        input logic [7:0]            delta,
        input logic                  neg,
        input logic [COORD_BITS-1:0] lim
    );
        logic [SUM_BITS-1:0] v;
        v = SUM_BITS'(pos) + SUM_BITS'(delta) - (neg ? SUM_BITS'(256) : SUM_BITS'(0));
        if (v[SUM_BITS-1]) begin
            return '0;
        end
        if (v > SUM_BITS'(lim)) begin
            return lim;
        end
        return COORD_BITS'(v);
    endfunction

    logic [CFG_BITS-1:0]   r_width, r_height;
    logic [COORD_BITS-1:0] r_cur_x, n_cur_x;
    logic [COORD_BITS-1:0] r_cur_y, n_cur_y;
    logic [COORD_BITS-1:0] w_lim_x, w_lim_y;
    logic                  r_valid;
    logic [1:0]            r_buttons;

    assign w_lim_x = cap_limit(r_width);
    assign w_lim_y = cap_limit(r_height);
    assign o_pop   = i_q_valid && (!r_valid || !i_stall);
    assign n_cur_x = move_axis(r_cur_x, i_packet.dx, i_packet.x_neg, w_lim_x);
    assign n_cur_y = move_axis(r_cur_y, i_packet.dy, i_packet.y_neg, w_lim_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
            r_cur_x  <= RESET_X;
            r_cur_y  <= RESET_Y;
            r_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                    CFG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_pop) begin
                r_cur_x <= n_cur_x;
                r_cur_y <= n_cur_y;
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
        if (o_pop) begin
            r_buttons <= i_packet.buttons;
        end
    end

    assign o_valid   = r_valid;
    assign o_pos_x   = OUT_BITS'(r_cur_x);
    assign o_pos_y   = OUT_BITS'(r_cur_y);
    assign o_buttons = r_buttons;

    `PMPT_ASSERT(a_x_in_limit, i_clk, i_rst_n, o_pop |=> (r_cur_x <= $past(w_lim_x)))
    `PMPT_ASSERT(a_y_in_limit, i_clk, i_rst_n, o_pop |=> (r_cur_y <= $past(w_lim_y)))
    `PMPT_ASSERT(a_hold_on_stall, i_clk, i_rst_n,
        (r_valid && i_stall) |=> (r_valid && $stable(r_cur_x) && $stable(r_cur_y)))

endmodule

`default_nettype wire

### src/ps2_mouse_packet_tracker.sv
// ---------------------------------------------------------------------------
// ps2_mouse_packet_tracker
// Turns a PS/2 mouse byte stream into clamped absolute pointer positions.
//
// Input channel: i_valid / o_stall carry one raw mouse byte per transfer.
// Bytes are dropped until a header with bit 3 set arrives; the next two
// bytes are the X and Y deltas. Output channel: o_valid / i_stall carry one
// result (position and buttons) per completed three-byte packet.
// One byte can be taken every cycle while o_stall is low. A result is shown
// after the transfer of the packet's Y byte, once it has passed through the
// packet queue and then the position update that loads the output register.
// When the receiver stalls, the result holds; the two-entry queue keeps
// taking packets, and o_stall rises only while that queue is full.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) set the screen
// width and height clamp limits and take effect on the next packet.
// Reset returns to header hunting, position 800,400, limits 1920 by 1080.
// ---------------------------------------------------------------------------
`default_nettype none

module ps2_mouse_packet_tracker
    import pmpt_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_idx,
    input  wire logic [CFG_BITS-1:0] i_cfg_data,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [7:0]          i_rx_byte,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [OUT_BITS-1:0]      o_pos_x,
    output logic [OUT_BITS-1:0]      o_pos_y,
    output logic [1:0]               o_buttons
);

    logic    w_push, w_full, w_q_valid, w_pop;
    t_packet w_in_packet, w_out_packet;

    pmpt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_rx_byte (i_rx_byte),
        .o_stall   (o_stall),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_packet  (w_in_packet)
    );

    pmpt_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_packet (w_in_packet),
        .o_full   (w_full),
        .o_valid  (w_q_valid),
        .o_packet (w_out_packet),
        .i_pop    (w_pop)
    );

    pmpt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (w_q_valid),
        .i_packet   (w_out_packet),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_pos_x    (o_pos_x),
        .o_pos_y    (o_pos_y),
        .o_buttons  (o_buttons)
    );

endmodule

`default_nettype wire
